/* design/nrx_pkg.sv */
// nrx_pkg: shared types, codes and constants of the NORX32 duplex core.
// No dependencies; imported by every design file.
package nrx_pkg;

    typedef logic [31:0]       nrx_word_t;
    typedef logic [15:0][31:0] nrx_state_t;

    localparam int RATE_BYTES = 48;
    localparam int RATE_BITS  = RATE_BYTES * 8;
    localparam int TAG_BYTES  = 16;

    localparam logic [2:0] KIND_INIT     = 3'd0;
    localparam logic [2:0] KIND_ABSORB   = 3'd1;
    localparam logic [2:0] KIND_ENCRYPT  = 3'd2;
    localparam logic [2:0] KIND_DECRYPT  = 3'd3;
    localparam logic [2:0] KIND_FINALIZE = 3'd4;

    localparam logic [2:0] CFG_KEY_LOW     = 3'd0;
    localparam logic [2:0] CFG_KEY_HIGH    = 3'd1;
    localparam logic [2:0] CFG_ROUND_COUNT = 3'd2;
    localparam logic [2:0] CFG_PARALLELISM = 3'd3;
    localparam logic [2:0] CFG_TAG_BITS    = 3'd4;

    localparam nrx_word_t INIT_U0 = 32'hA3D8D930;
    localparam nrx_word_t INIT_U1 = 32'h3FA8B72C;
    localparam nrx_word_t INIT_U2 = 32'hED84EB49;
    localparam nrx_word_t INIT_U3 = 32'hEDCA4787;
    localparam nrx_word_t INIT_U4 = 32'h335463EB;
    localparam nrx_word_t INIT_U5 = 32'hF994220B;
    localparam nrx_word_t INIT_U6 = 32'hBE0BF5C9;
    localparam nrx_word_t INIT_U7 = 32'hD7C49104;
    localparam nrx_word_t WORD_SIZE = 32'd32;

    localparam logic [7:0] PAD_FIRST = 8'h01;
    localparam logic [7:0] PAD_LAST  = 8'h80;

    // NORX nonlinear "add"
    function automatic nrx_word_t nrx_h(input nrx_word_t a, input nrx_word_t b);
        return a ^ b ^ ((a & b) << 1);
    endfunction

endpackage

/* design/nrx_lane.sv */
// nrx_lane: one G function lane (four H/rotate steps) of the NORX32 permutation.
// Depends on nrx_pkg.
module nrx_lane
    import nrx_pkg::*;
(
    input  nrx_word_t a_i,
    input  nrx_word_t b_i,
    input  nrx_word_t c_i,
    input  nrx_word_t d_i,
    output nrx_word_t a_o,
    output nrx_word_t b_o,
    output nrx_word_t c_o,
    output nrx_word_t d_o
);

    nrx_word_t a1, b1, c1, d1, a2, b2, c2, d2, t;

    always_comb begin
        a1 = nrx_h(a_i, b_i);
        t  = d_i ^ a1;
        d1 = {t[7:0], t[31:8]};
        c1 = nrx_h(c_i, d1);
        t  = b_i ^ c1;
        b1 = {t[10:0], t[31:11]};
        a2 = nrx_h(a1, b1);
        t  = d1 ^ a2;
        d2 = {t[15:0], t[31:16]};
        c2 = nrx_h(c1, d2);
        t  = b1 ^ c2;
        b2 = {t[30:0], t[31]};
    end

    assign a_o = a2;
    assign b_o = b2;
    assign c_o = c2;
    assign d_o = d2;

endmodule

/* design/nrx_half_round.sv */
// nrx_half_round: four G lanes side by side on the column or diagonal words,
// with the routing that merges lane results back into the state. Uses nrx_lane.
module nrx_half_round
    import nrx_pkg::*;
(
    input  nrx_state_t st_i,
    input  logic       diag_i,
    output nrx_state_t st_o
);

    localparam logic [3:0] COL_A [4] = '{4'd0, 4'd1, 4'd2, 4'd3};
    localparam logic [3:0] COL_B [4] = '{4'd4, 4'd5, 4'd6, 4'd7};
    localparam logic [3:0] COL_C [4] = '{4'd8, 4'd9, 4'd10, 4'd11};
    localparam logic [3:0] COL_D [4] = '{4'd12, 4'd13, 4'd14, 4'd15};
    localparam logic [3:0] DIA_B [4] = '{4'd5, 4'd6, 4'd7, 4'd4};
    localparam logic [3:0] DIA_C [4] = '{4'd10, 4'd11, 4'd8, 4'd9};
    localparam logic [3:0] DIA_D [4] = '{4'd15, 4'd12, 4'd13, 4'd14};

    nrx_word_t la [4], lb [4], lc [4], ld [4];
    nrx_word_t ra [4], rb [4], rc [4], rd [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            la[l] = st_i[COL_A[l]];
            lb[l] = diag_i ? st_i[DIA_B[l]] : st_i[COL_B[l]];
            lc[l] = diag_i ? st_i[DIA_C[l]] : st_i[COL_C[l]];
            ld[l] = diag_i ? st_i[DIA_D[l]] : st_i[COL_D[l]];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        nrx_lane u_lane (
            .a_i(la[g]), .b_i(lb[g]), .c_i(lc[g]), .d_i(ld[g]),
            .a_o(ra[g]), .b_o(rb[g]), .c_o(rc[g]), .d_o(rd[g])
        );
    end

    always_comb begin
        st_o = st_i;
        for (int l = 0; l < 4; l++) begin
            st_o[COL_A[l]] = ra[l];
            if (diag_i) begin
                st_o[DIA_B[l]] = rb[l];
                st_o[DIA_C[l]] = rc[l];
                st_o[DIA_D[l]] = rd[l];
            end else begin
                st_o[COL_B[l]] = rb[l];
                st_o[COL_C[l]] = rc[l];
                st_o[COL_D[l]] = rd[l];
            end
        end
    end

endmodule

/* design/norx32_duplex_core_unit.sv */
// norx32_duplex_core_unit: NORX32 duplex core top level: sequencer, state,
// block padding and result register. Depends on nrx_pkg and nrx_half_round.
//
//  channel | dir | signals                      | word layout (lsb up)
//  s_      | in  | s_tvalid s_tready s_tdata/u | tuser: kind; tdata: domain, data0..5,
//          |     |                              |        valid_bytes, 2 zero bits
//  m_      | out | m_tvalid m_tready m_tdata    | tdata: out0..out5, out_bytes, 2 zero
//  cfg_    | in  | cfg_we cfg_index cfg_wdata   | write only, index 0..4
//
// One half-round (four G lanes) per cycle. After accept an item runs the
// permutation, then ST_POST; finalize runs the permutation twice.
// A result waits in the output register; the next word is accepted meanwhile and
// the core holds before its own result only if that register is still full.
// Reset (aresetn low, synchronous) clears the state to zero and config to defaults.
module norx32_duplex_core_unit
    import nrx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [399:0] s_tdata,   // domain, data0..data5, valid_bytes, zero pad
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [391:0] m_tdata,   // out0..out5, out_bytes, zero pad
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PERM = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    logic [63:0]         key_low_reg, key_high_reg;
    logic [4:0]          round_count_reg;
    logic [7:0]          parallelism_reg, tag_bits_reg;

    logic [1:0]          fsm_reg, fsm_next;
    nrx_state_t          st_reg, st_next, hr_out;
    logic [4:0]          rnd_reg, rnd_next;
    logic                diag_reg, diag_next;
    logic [2:0]          kind_reg;
    logic                fin_reg, fin_next;
    logic [RATE_BITS-1:0] blk_reg;
    logic [RATE_BYTES-1:0] mask_reg;
    logic [5:0]          nbytes_reg;
    logic                m_valid_reg, m_valid_next;
    logic [391:0]        m_data_reg;
    logic [391:0]        m_data_next;

    logic                s_fire, kind_ok, out_free;
    logic [2:0]          in_kind;
    logic [7:0]          in_domain;
    logic [RATE_BITS-1:0] in_data;
    logic [5:0]          in_n;
    logic [RATE_BITS-1:0] pad_blk;
    logic [RATE_BYTES-1:0] pad_mask;
    nrx_state_t          init_st, keyed_st;
    logic [RATE_BITS-1:0] rate_vec, xor_vec, dec_vec, res_vec;
    logic [4:0]          tag_len;
    logic [127:0]        tag_src;
    logic [127:0]        tag_vec;

    assign in_kind   = s_tuser;
    assign in_domain = s_tdata[7:0];
    assign in_data   = s_tdata[391:8];
    assign in_n      = (s_tdata[397:392] > 6'(RATE_BYTES)) ? 6'(RATE_BYTES)
                                                           : s_tdata[397:392];
    assign kind_ok   = (in_kind <= KIND_FINALIZE);
    assign s_tready  = (fsm_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // padded block and valid-byte mask, formed at accept
    always_comb begin
        for (int i = 0; i < RATE_BYTES; i++) begin
            pad_mask[i] = (6'(i) < in_n);
            if (pad_mask[i]) begin
                pad_blk[8*i +: 8] = in_data[8*i +: 8];
            end else begin
                pad_blk[8*i +: 8] = ((6'(i) == in_n) ? PAD_FIRST : 8'h00) ^
                    (((i == RATE_BYTES - 1) && (in_n != 6'(RATE_BYTES))) ? PAD_LAST : 8'h00);
            end
        end
    end

    always_comb begin
        init_st[0]  = in_data[31:0];
        init_st[1]  = in_data[63:32];
        init_st[2]  = in_data[95:64];
        init_st[3]  = in_data[127:96];
        init_st[4]  = key_low_reg[31:0];
        init_st[5]  = key_low_reg[63:32];
        init_st[6]  = key_high_reg[31:0];
        init_st[7]  = key_high_reg[63:32];
        init_st[8]  = INIT_U0;
        init_st[9]  = INIT_U1;
        init_st[10] = INIT_U2;
        init_st[11] = INIT_U3;
        init_st[12] = INIT_U4 ^ WORD_SIZE;
        init_st[13] = INIT_U5 ^ {27'd0, round_count_reg};
        init_st[14] = INIT_U6 ^ {24'd0, parallelism_reg};
        init_st[15] = INIT_U7 ^ {24'd0, tag_bits_reg};
    end

    nrx_half_round u_half_round (
        .st_i  (st_reg),
        .diag_i(diag_reg),
        .st_o  (hr_out)
    );

    always_comb begin
        keyed_st     = st_reg;
        keyed_st[12] = st_reg[12] ^ key_low_reg[31:0];
        keyed_st[13] = st_reg[13] ^ key_low_reg[63:32];
        keyed_st[14] = st_reg[14] ^ key_high_reg[31:0];
        keyed_st[15] = st_reg[15] ^ key_high_reg[63:32];
    end

    assign rate_vec = st_reg[11:0];
    assign xor_vec  = rate_vec ^ blk_reg;

    always_comb begin
        for (int i = 0; i < RATE_BYTES; i++) begin
            dec_vec[8*i +: 8] = mask_reg[i] ? blk_reg[8*i +: 8] : xor_vec[8*i +: 8];
            res_vec[8*i +: 8] = mask_reg[i] ? xor_vec[8*i +: 8] : 8'h00;
        end
    end

    assign tag_len = (tag_bits_reg[7:3] > 5'(TAG_BYTES)) ? 5'(TAG_BYTES) : tag_bits_reg[7:3];
    assign tag_src = keyed_st[15:12];

    always_comb begin
        for (int i = 0; i < TAG_BYTES; i++) begin
            tag_vec[8*i +: 8] = (5'(i) < tag_len) ? tag_src[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        fsm_next     = fsm_reg;
        st_next      = st_reg;
        rnd_next     = rnd_reg;
        diag_next    = diag_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (fsm_reg)
            ST_IDLE: begin
                if (s_fire && kind_ok) begin
                    rnd_next  = 5'd0;
                    diag_next = 1'b0;
                    fin_next  = 1'b0;
                    fsm_next  = (round_count_reg == 5'd0) ? ST_POST : ST_PERM;
                    if (in_kind == KIND_INIT) begin
                        st_next = init_st;
                    end else begin
                        st_next[15] = st_reg[15] ^ {24'd0, in_domain};
                    end
                end
            end
            ST_PERM: begin
                st_next   = hr_out;
                diag_next = !diag_reg;
                if (diag_reg) begin
                    rnd_next = rnd_reg + 5'd1;
                    if (rnd_reg == round_count_reg - 5'd1) begin
                        fsm_next = ST_POST;
                    end
                end
            end
            ST_POST: begin
                unique case (kind_reg)
                    KIND_INIT: begin
                        st_next  = keyed_st;
                        fsm_next = ST_IDLE;
                    end
                    KIND_ABSORB: begin
                        st_next[11:0] = xor_vec;
                        fsm_next      = ST_IDLE;
                    end
                    KIND_ENCRYPT, KIND_DECRYPT: begin
                        if (out_free) begin
                            st_next[11:0] = (kind_reg == KIND_DECRYPT) ? dec_vec : xor_vec;
                            m_valid_next  = 1'b1;
                            m_data_next   = {2'b00, nbytes_reg, res_vec};
                            fsm_next      = ST_IDLE;
                        end
                    end
                    KIND_FINALIZE: begin
                        if (!fin_reg) begin
                            st_next   = keyed_st;
                            fin_next  = 1'b1;
                            rnd_next  = 5'd0;
                            diag_next = 1'b0;
                            fsm_next  = (round_count_reg == 5'd0) ? ST_POST : ST_PERM;
                        end else if (out_free) begin
                            st_next      = keyed_st;
                            m_valid_next = 1'b1;
                            m_data_next  = {2'b00, 1'b0, tag_len,
                                            256'd0, tag_vec};
                            fsm_next     = ST_IDLE;
                        end
                    end
                    default: fsm_next = ST_IDLE;
                endcase
            end
            default: fsm_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg         <= ST_IDLE;
            st_reg          <= '0;
            rnd_reg         <= '0;
            diag_reg        <= 1'b0;
            fin_reg         <= 1'b0;
            kind_reg        <= KIND_INIT;
            m_valid_reg     <= 1'b0;
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            round_count_reg <= 5'd4;
            parallelism_reg <= 8'd1;
            tag_bits_reg    <= 8'd128;
        end else begin
            fsm_reg     <= fsm_next;
            st_reg      <= st_next;
            rnd_reg     <= rnd_next;
            diag_reg    <= diag_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
            if (s_fire && kind_ok) begin
                kind_reg <= in_kind;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY_LOW:     key_low_reg     <= cfg_wdata;
                    CFG_KEY_HIGH:    key_high_reg    <= cfg_wdata;
                    CFG_ROUND_COUNT: round_count_reg <= cfg_wdata[4:0];
                    CFG_PARALLELISM: parallelism_reg <= cfg_wdata[7:0];
                    CFG_TAG_BITS:    tag_bits_reg    <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_fire) begin
            blk_reg    <= pad_blk;
            mask_reg   <= pad_mask;
            nbytes_reg <= in_n;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* design/nrx_checker.sv */
// nrx_checker: port-level assertions for norx32_duplex_core_unit, bound to the top.
// Depends on nrx_pkg and the top level's ports.
module nrx_checker
    import nrx_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [391:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser <= KIND_FINALIZE) |=> !s_tready)
        else $error("input taken while previous word still in work");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[389:384] <= 6'd48)
        else $error("out_bytes beyond block size");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after accept");

endmodule

bind norx32_duplex_core_unit nrx_checker u_nrx_checker (.*);
